// File: hw/rtl/lsdacs_pkg.sv
package lsdacs_pkg;

    // Byte values of the header and of ULEB128 framing
    localparam logic [7:0] OMIT_ENC     = 8'hFF;
    localparam logic [7:0] UDATA4_ENC   = 8'h03;
    localparam logic [7:0] ULEB_PAYLOAD = 8'h7F;
    localparam logic [7:0] ULEB_MORE    = 8'h80;

    localparam int unsigned ULEB_STEP      = 7;
    localparam int unsigned ULEB_LIMIT     = 64;
    localparam int unsigned IN_DATA_WIDTH  = 104;
    localparam int unsigned OUT_DATA_WIDTH = 72;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_TTYPE_ENC = 4'd1,
        PH_TTYPE_OFF = 4'd2,
        PH_CS_ENC    = 4'd3,
        PH_TABLE_LEN = 4'd4,
        PH_E_START   = 4'd5,
        PH_E_LEN     = 4'd6,
        PH_E_PAD     = 4'd7,
        PH_E_ACTION  = 4'd8,
        PH_DONE      = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        OUT_BAD   = 2'd0,
        OUT_PAD   = 2'd1,
        OUT_NOPAD = 2'd2,
        OUT_NONE  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [63:0] function_start;
        logic [31:0] call_offset;
        logic        first_byte;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic        valid;
        logic        found;
        logic [63:0] pad_address;
        outcome_t    outcome;
    } result_t;

endpackage

// File: hw/rtl/lsdacs_parser.sv
module lsdacs_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  lsdacs_pkg::in_item_t item,
    output lsdacs_pkg::result_t  result
);
    import lsdacs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [31:0] uleb_acc_reg, uleb_acc_next;
    logic        uleb_ovf_reg, uleb_ovf_next;
    logic [6:0]  uleb_shift_reg, uleb_shift_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] e_start_reg, e_start_next;
    logic [31:0] e_len_reg, e_len_next;
    logic [31:0] e_pad_reg, e_pad_next;
    logic [31:0] call_off_reg, call_off_next;
    logic [63:0] func_start_reg, func_start_next;

    logic [7:0]  b;
    logic [63:0] uleb_shifted;
    logic [31:0] uleb_acc_new;
    logic        uleb_ovf_new;
    logic [32:0] range_end;
    logic        covers;
    logic [31:0] bytes_left_dec;
    logic [63:0] pad_sum;

    assign b = item.data_byte;

    // Place this byte's seven payload bits at the current shift
    assign uleb_shifted = {57'd0, b[6:0] & ULEB_PAYLOAD[6:0]} << uleb_shift_reg;
    assign uleb_acc_new = (uleb_shift_reg < 7'(ULEB_LIMIT)) ?
                          (uleb_acc_reg | uleb_shifted[31:0]) : uleb_acc_reg;
    assign uleb_ovf_new = uleb_ovf_reg |
                          ((uleb_shift_reg < 7'(ULEB_LIMIT)) && (|uleb_shifted[63:32]));

    // Range check of the current entry in 33 bits
    assign range_end = {1'b0, e_start_reg} + {1'b0, e_len_reg};
    assign covers    = (call_off_reg >= e_start_reg) && ({1'b0, call_off_reg} < range_end);
    assign pad_sum   = func_start_reg + {32'd0, e_pad_reg};

    always_comb begin
        // Count down table bytes while inside entries
        bytes_left_dec = bytes_left_reg;
        if ((phase_reg == PH_E_START || phase_reg == PH_E_LEN || phase_reg == PH_E_PAD ||
             phase_reg == PH_E_ACTION) && bytes_left_reg != 32'd0) begin
            bytes_left_dec = bytes_left_reg - 32'd1;
        end

        phase_next      = phase_reg;
        byte_idx_next   = byte_idx_reg;
        uleb_acc_next   = uleb_acc_reg;
        uleb_ovf_next   = uleb_ovf_reg;
        uleb_shift_next = uleb_shift_reg;
        bytes_left_next = bytes_left_reg;
        e_start_next    = e_start_reg;
        e_len_next      = e_len_reg;
        e_pad_next      = e_pad_reg;
        call_off_next   = call_off_reg;
        func_start_next = func_start_reg;
        result          = '{valid: 1'b0, found: 1'b0, pad_address: 64'd0, outcome: OUT_BAD};

        if (item.first_byte) begin
            // Start a new scan, abandoning any scan in progress
            call_off_next   = item.call_offset;
            func_start_next = item.function_start;
            if (b != OMIT_ENC) begin
                result.valid = 1'b1;
                phase_next   = PH_DONE;
            end else begin
                phase_next = PH_TTYPE_ENC;
            end
        end else begin
            bytes_left_next = bytes_left_dec;
            unique case (phase_reg) inside
                PH_TTYPE_ENC: begin
                    phase_next = (b != OMIT_ENC) ? PH_TTYPE_OFF : PH_CS_ENC;
                end
                PH_TTYPE_OFF: begin
                    if ((b & ULEB_MORE) == 8'd0) phase_next = PH_CS_ENC;
                end
                PH_CS_ENC: begin
                    if (b != UDATA4_ENC) begin
                        result.valid = 1'b1;
                        phase_next   = PH_DONE;
                    end else begin
                        uleb_acc_next   = 32'd0;
                        uleb_ovf_next   = 1'b0;
                        uleb_shift_next = 7'd0;
                        phase_next      = PH_TABLE_LEN;
                    end
                end
                PH_TABLE_LEN: begin
                    uleb_acc_next = uleb_acc_new;
                    uleb_ovf_next = uleb_ovf_new;
                    if (uleb_shift_reg < 7'(ULEB_LIMIT)) begin
                        uleb_shift_next = uleb_shift_reg + 7'(ULEB_STEP);
                    end
                    if ((b & ULEB_MORE) == 8'd0) begin
                        // Saturate the length to 32 bits
                        bytes_left_next = uleb_ovf_new ? 32'hFFFF_FFFF : uleb_acc_new;
                        if (!uleb_ovf_new && uleb_acc_new == 32'd0) begin
                            result.valid   = 1'b1;
                            result.outcome = OUT_NONE;
                            phase_next     = PH_DONE;
                        end else begin
                            byte_idx_next = 2'd0;
                            e_start_next  = 32'd0;
                            phase_next    = PH_E_START;
                        end
                    end
                end
                PH_E_START, PH_E_LEN, PH_E_PAD: begin
                    // Fill one byte lane of the little-endian word
                    if (phase_reg == PH_E_START) begin
                        e_start_next[byte_idx_reg*8 +: 8] = b;
                    end else if (phase_reg == PH_E_LEN) begin
                        e_len_next[byte_idx_reg*8 +: 8] = b;
                    end else begin
                        e_pad_next[byte_idx_reg*8 +: 8] = b;
                    end
                    byte_idx_next = byte_idx_reg + 2'd1;
                    if (byte_idx_reg == 2'd3) begin
                        if (phase_reg == PH_E_START) begin
                            e_len_next = 32'd0;
                            phase_next = PH_E_LEN;
                        end else if (phase_reg == PH_E_LEN) begin
                            e_pad_next = 32'd0;
                            phase_next = PH_E_PAD;
                        end else begin
                            phase_next = PH_E_ACTION;
                        end
                    end
                end
                PH_E_ACTION: begin
                    if ((b & ULEB_MORE) == 8'd0) begin
                        if (covers) begin
                            result.valid = 1'b1;
                            phase_next   = PH_DONE;
                            if (e_pad_reg != 32'd0) begin
                                result.found       = 1'b1;
                                result.pad_address = pad_sum;
                                result.outcome     = OUT_PAD;
                            end else begin
                                result.outcome = OUT_NOPAD;
                            end
                        end else if (bytes_left_dec == 32'd0) begin
                            result.valid   = 1'b1;
                            result.outcome = OUT_NONE;
                            phase_next     = PH_DONE;
                        end else begin
                            byte_idx_next = 2'd0;
                            e_start_next  = 32'd0;
                            phase_next    = PH_E_START;
                        end
                    end
                end
                default: begin
                    // Idle or done: drop the byte
                end
            endcase
        end

        if (!step) begin
            result.valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_idx_reg   <= 2'd0;
            uleb_acc_reg   <= 32'd0;
            uleb_ovf_reg   <= 1'b0;
            uleb_shift_reg <= 7'd0;
            bytes_left_reg <= 32'd0;
            e_start_reg    <= 32'd0;
            e_len_reg      <= 32'd0;
            e_pad_reg      <= 32'd0;
            call_off_reg   <= 32'd0;
            func_start_reg <= 64'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            byte_idx_reg   <= byte_idx_next;
            uleb_acc_reg   <= uleb_acc_next;
            uleb_ovf_reg   <= uleb_ovf_next;
            uleb_shift_reg <= uleb_shift_next;
            bytes_left_reg <= bytes_left_next;
            e_start_reg    <= e_start_next;
            e_len_reg      <= e_len_next;
            e_pad_reg      <= e_pad_next;
            call_off_reg   <= call_off_next;
            func_start_reg <= func_start_next;
        end
    end

endmodule

// File: hw/rtl/lsda_call_site_pad_lookup.sv
// Channel   Dir  Signals                            Content
// s_axis    in   tvalid tready tdata[103:0] tuser   one table byte with scan context
// m_axis    out  tvalid tready tdata[71:0]          lookup result, at most one per scan
//
// One item per cycle while the result is not stalled: an input register
// feeds the parser, which updates its state and fills the result register
// in the same cycle; the result then waits in that register until taken.
// aresetn is synchronous and active low; it returns the parser to idle.
// A stalled result holds the parser; the input register still takes one item.
module lsda_call_site_pad_lookup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] data_byte, [39:8] call_offset, [103:40] function_start
    input  logic [lsdacs_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
    // [0] first_byte
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] found, [64:1] pad_address, [66:65] outcome, [71:67] zero
    output logic [lsdacs_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);
    import lsdacs_pkg::*;

    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;
    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg;
    result_t  res;
    logic     advance;
    logic     step;
    logic     in_accept;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    lsdacs_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (res)
    );

    // Hold or refill the input register and the result valid flag
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? res.valid : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_item_reg.data_byte      <= s_axis_tdata[7:0];
            in_item_reg.call_offset    <= s_axis_tdata[39:8];
            in_item_reg.function_start <= s_axis_tdata[103:40];
            in_item_reg.first_byte     <= s_axis_tuser;
        end
        if (advance && res.valid) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.outcome, out_res_reg.pad_address,
                            out_res_reg.found};

endmodule

// File: bench/lsda_call_site_pad_lookup_tb.sv
`timescale 1ns / 1ps

module lsda_call_site_pad_lookup_tb;

    import lsdacs_pkg::*;

    typedef struct {
        logic        found;
        logic [63:0] pad_address;
        outcome_t    outcome;
    } lookup_result_t;

    // Track the parse of each table scan and queue the lookup result it yields
    class pad_lookup_scoreboard;
        lookup_result_t expected_results[$];
        int unsigned    mismatches;
        phase_t         phase;
        logic [1:0]     byte_idx;
        logic [63:0]    uleb_acc;
        logic [6:0]     uleb_shift;
        logic [31:0]    bytes_left;
        logic [31:0]    ent_start;
        logic [31:0]    ent_length;
        logic [31:0]    ent_pad;
        logic [31:0]    call_offset;
        logic [63:0]    func_start;

        function new();
            mismatches  = 0;
            phase       = PH_IDLE;
            byte_idx    = '0;
            uleb_acc    = '0;
            uleb_shift  = '0;
            bytes_left  = '0;
            ent_start   = '0;
            ent_length  = '0;
            ent_pad     = '0;
            call_offset = '0;
            func_start  = '0;
        endfunction

        function void finish_scan(outcome_t oc, logic [63:0] addr);
            lookup_result_t r;
            r.found       = (oc == OUT_PAD);
            r.pad_address = (oc == OUT_PAD) ? addr : 64'd0;
            r.outcome     = oc;
            expected_results.push_back(r);
            phase = PH_DONE;
        endfunction

        function void note_byte(in_item_t it);
            logic [7:0]  b;
            logic [31:0] lane;
            b    = it.data_byte;
            lane = 32'(b) << (8 * byte_idx);

            // A marked byte restarts the scan and must be the omitted base encoding
            if (it.first_byte) begin
                call_offset = it.call_offset;
                func_start  = it.function_start;
                if (b != OMIT_ENC)
                    finish_scan(OUT_BAD, '0);
                else
                    phase = PH_TTYPE_ENC;
                return;
            end

            // Count down the table length on entry bytes, stopping at zero
            if (phase >= PH_E_START && phase <= PH_E_ACTION && bytes_left != 0)
                bytes_left--;

            case (phase)
                PH_TTYPE_ENC: begin
                    if (b != OMIT_ENC)
                        phase = PH_TTYPE_OFF;
                    else
                        phase = PH_CS_ENC;
                end
                PH_TTYPE_OFF: begin
                    if ((b & ULEB_MORE) == 0)
                        phase = PH_CS_ENC;
                end
                PH_CS_ENC: begin
                    if (b != UDATA4_ENC) begin
                        finish_scan(OUT_BAD, '0);
                    end else begin
                        uleb_acc   = '0;
                        uleb_shift = '0;
                        phase      = PH_TABLE_LEN;
                    end
                end
                PH_TABLE_LEN: begin
                    // Drop payload bits beyond the accumulator width
                    if (uleb_shift < ULEB_LIMIT) begin
                        uleb_acc   = uleb_acc | (64'(b & ULEB_PAYLOAD) << uleb_shift);
                        uleb_shift = uleb_shift + 7'(ULEB_STEP);
                    end
                    if ((b & ULEB_MORE) == 0) begin
                        bytes_left = (uleb_acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : uleb_acc[31:0];
                        if (bytes_left == 0) begin
                            finish_scan(OUT_NONE, '0);
                        end else begin
                            byte_idx  = '0;
                            ent_start = '0;
                            phase     = PH_E_START;
                        end
                    end
                end
                PH_E_START, PH_E_LEN, PH_E_PAD: begin
                    if (phase == PH_E_START)
                        ent_start = ent_start | lane;
                    else if (phase == PH_E_LEN)
                        ent_length = ent_length | lane;
                    else
                        ent_pad = ent_pad | lane;
                    if (byte_idx < 2'd3) begin
                        byte_idx++;
                    end else begin
                        byte_idx = '0;
                        if (phase == PH_E_START) begin
                            ent_length = '0;
                            phase      = PH_E_LEN;
                        end else if (phase == PH_E_LEN) begin
                            ent_pad = '0;
                            phase   = PH_E_PAD;
                        end else begin
                            phase = PH_E_ACTION;
                        end
                    end
                end
                PH_E_ACTION: begin
                    if ((b & ULEB_MORE) == 0) begin
                        // Range check is done in 64 bits so start + length cannot wrap
                        if ({32'd0, call_offset} >= {32'd0, ent_start} &&
                            {32'd0, call_offset} < {32'd0, ent_start} + {32'd0, ent_length}) begin
                            if (ent_pad != 0)
                                finish_scan(OUT_PAD, func_start + {32'd0, ent_pad});
                            else
                                finish_scan(OUT_NOPAD, '0);
                        end else if (bytes_left == 0) begin
                            finish_scan(OUT_NONE, '0);
                        end else begin
                            byte_idx  = '0;
                            ent_start = '0;
                            phase     = PH_E_START;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [OUT_DATA_WIDTH-1:0] d);
            lookup_result_t exp_r;
            if (expected_results.size() == 0) begin
                $error("unexpected result: found=%0d pad_address=%h outcome=%0d",
                       d[0], d[64:1], d[66:65]);
                mismatches++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (d[0] !== exp_r.found) begin
                $error("found: expected %0d, actual %0d", exp_r.found, d[0]);
                mismatches++;
            end
            if (d[64:1] !== exp_r.pad_address) begin
                $error("pad_address: expected %h, actual %h", exp_r.pad_address, d[64:1]);
                mismatches++;
            end
            if (d[66:65] !== exp_r.outcome) begin
                $error("outcome: expected %0d, actual %0d", exp_r.outcome, d[66:65]);
                mismatches++;
            end
            if (d[71:67] !== 5'd0) begin
                $error("reserved bits: expected 0, actual %h", d[71:67]);
                mismatches++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]  s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

    pad_lookup_scoreboard sb;
    int unsigned          send_idle_pct;
    int unsigned          recv_idle_pct;
    logic [7:0]           scan_q[$];
    logic [7:0]           ent_q[$];
    logic [7:0]           uleb_q[$];
    logic [31:0]          scan_co;
    logic [63:0]          scan_fs;

    lsda_call_site_pad_lookup DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall the result channel at random
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one byte, idling at random first, and hold it until accepted
    task automatic send_item(logic [7:0] b, logic first, logic [31:0] co, logic [63:0] fs);
        in_item_t it;
        it.data_byte      = b;
        it.first_byte     = first;
        it.call_offset    = co;
        it.function_start = fs;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {fs, co, b};
        s_axis_tuser  = first;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_byte(it);
    endtask

    // Send the queued scan; context fields only matter on the marked byte
    task automatic send_scan();
        foreach (scan_q[i]) begin
            if (i == 0)
                send_item(scan_q[i], 1'b1, scan_co, scan_fs);
            else
                send_item(scan_q[i], 1'b0, $urandom, {$urandom, $urandom});
        end
    endtask

    // Hold off the sender until every pending lookup has come back
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    // Encode v as ULEB128 with redundant continuation bytes appended
    function automatic void encode_uleb(logic [63:0] v, int pad);
        logic [7:0] b;
        uleb_q.delete();
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0 || pad > 0)
                b = b | ULEB_MORE;
            uleb_q.push_back(b);
        end while (v != 0);
        while (pad > 0) begin
            pad--;
            uleb_q.push_back((pad > 0) ? ULEB_MORE : 8'h00);
        end
    endfunction

    function automatic void push_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            ent_q.push_back(w[8*i +: 8]);
    endfunction

    // Build one scan: a mostly valid header, some entries, a chosen table length
    task automatic build_scan();
        int          n_ent;
        int          cover_idx;
        int          r;
        logic [31:0] d;
        logic [31:0] st;
        logic [31:0] ln;
        logic [7:0]  b;
        scan_q.delete();
        ent_q.delete();
        case ($urandom_range(0, 7))
            0:       scan_co = 32'd0;
            1:       scan_co = 32'hFFFF_FFFF;
            2:       scan_co = $urandom_range(0, 255);
            default: scan_co = $urandom;
        endcase
        scan_fs = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
        r = $urandom_range(0, 99);

        // Header: base, type-table encoding with optional offset, call-site encoding
        scan_q.push_back((r < 4) ? 8'($urandom_range(0, 254)) : OMIT_ENC);
        if ($urandom_range(0, 1) == 0) begin
            scan_q.push_back(OMIT_ENC);
        end else begin
            scan_q.push_back(8'($urandom_range(0, 254)));
            encode_uleb($urandom_range(0, 20000), $urandom_range(0, 1));
            foreach (uleb_q[i]) scan_q.push_back(uleb_q[i]);
        end
        if (r >= 4 && r < 8) begin
            b = 8'($urandom_range(0, 255));
            scan_q.push_back((b == UDATA4_ENC) ? 8'h04 : b);
        end else begin
            scan_q.push_back(UDATA4_ENC);
        end

        // Entries: those before the covering one miss the call offset
        n_ent     = $urandom_range(0, 4);
        cover_idx = $urandom_range(0, n_ent);
        for (int e = 0; e < n_ent; e++) begin
            d = (scan_co < 1000) ? $urandom_range(0, scan_co) : $urandom_range(0, 1000);
            if (e == cover_idx) begin
                st = scan_co - d;
                ln = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF
                                                 : d + 1 + $urandom_range(0, 5000);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        st = $urandom;
                        ln = 32'd0;
                    end
                    1: begin
                        st = scan_co + 1 + $urandom_range(0, 1000);
                        ln = $urandom;
                    end
                    default: begin
                        st = scan_co - d;
                        ln = d;
                    end
                endcase
            end
            push_word(st);
            push_word(ln);
            push_word(($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
            encode_uleb($urandom_range(0, 300), $urandom_range(0, 1));
            foreach (uleb_q[i]) ent_q.push_back(uleb_q[i]);
        end

        // Table length: exact, short, long, saturating or over-long encoding
        r = $urandom_range(0, 99);
        if (r < 70) begin
            encode_uleb(ent_q.size(), $urandom_range(0, 1));
        end else if (r < 80) begin
            encode_uleb($urandom_range(0, ent_q.size()), 0);
        end else if (r < 88) begin
            encode_uleb(ent_q.size() + $urandom_range(1, 30), 0);
        end else if (r < 94) begin
            encode_uleb({32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)}, 0);
        end else begin
            uleb_q.delete();
            for (int i = 0; i < 10; i++)
                uleb_q.push_back(ULEB_MORE | 8'($urandom_range(0, 127)));
            uleb_q.push_back(8'($urandom_range(0, 127)));
        end
        foreach (uleb_q[i]) scan_q.push_back(uleb_q[i]);
        foreach (ent_q[i]) scan_q.push_back(ent_q[i]);

        // Now and then cut the scan short so the next marked byte restarts it
        if ($urandom_range(0, 19) == 0 && scan_q.size() > 1) begin
            r = $urandom_range(1, scan_q.size() - 1);
            while (scan_q.size() > r) scan_q.pop_back();
        end
    endtask

    initial begin
        int sent;
        sb            = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn       = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: stray byte while idle, bad base, bad call-site encoding,
        // empty table, then a hit whose range end overflows 32 bits and
        // whose pad address wraps
        send_item(8'h5A, 1'b0, 32'h1234_5678, 64'h0);
        scan_q  = '{8'h00};
        scan_co = 32'hFFFF_FFFF;
        scan_fs = '1;
        send_scan();
        scan_q  = '{OMIT_ENC, OMIT_ENC, 8'h05};
        scan_co = 32'd0;
        scan_fs = '0;
        send_scan();
        scan_q = '{OMIT_ENC, OMIT_ENC, UDATA4_ENC, 8'h00};
        send_scan();
        scan_q  = '{OMIT_ENC, OMIT_ENC, UDATA4_ENC, 8'h0D,
                    8'hF0, 8'hFF, 8'hFF, 8'hFF,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h02, 8'h00, 8'h00, 8'h00,
                    8'h00};
        scan_co = 32'hFFFF_FFFF;
        scan_fs = '1;
        send_scan();
        drain();

        // Random scans under three idling profiles
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 7 : (p == 1) ? 60 : 0;
            recv_idle_pct = (p == 0) ? 60 : (p == 1) ? 7 : 0;
            sent = 0;
            while (sent < 400) begin
                build_scan();
                send_scan();
                sent += scan_q.size();
                // Trailing bytes after a result are ignored
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3))
                        send_item(8'($urandom), 1'b0, $urandom, {$urandom, $urandom});
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lsdacs_pkg.sv
hw/rtl/lsdacs_parser.sv
hw/rtl/lsda_call_site_pad_lookup.sv
bench/lsda_call_site_pad_lookup_tb.sv
